// ===== rtl/tise_pkg.sv =====
// shared constants for the thor ifk symbol encoder
package tise_pkg;

    // payload and register widths
    localparam int CODE_W    = 12;
    localparam int LEN_W     = 4;
    localparam int TONE_W    = 5;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int ENC_W     = 8;
    localparam int PRE_CNT_W = 5;
    localparam int DATA_CNT_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POLY_A       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLY_B       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE_LEN = 2'd2;

    // reset values
    localparam logic [CFG_W-1:0] POLY_A_RESET       = 8'd109;
    localparam logic [CFG_W-1:0] POLY_B_RESET       = 8'd79;
    localparam logic [CFG_W-1:0] PREAMBLE_LEN_RESET = 8'd16;

    // per-request limits
    localparam logic [LEN_W-1:0]     MAX_BITS          = 4'd12;
    localparam logic [PRE_CNT_W-1:0] PREAMBLE_PER_ITEM = 5'd16;

    // parameter defaults
    localparam int INTERLEAVE_DEPTH_DEF = 10;
    localparam int TONE_COUNT_DEF       = 18;

endpackage

// ===== rtl/thor_ifk_symbol_encoder_top.sv =====
// thor ifk symbol encoder: preamble, convolutional coder, interleaver, tone stepping
//
//  channel   handshake              payload
//  -------   --------------------   ---------------------------
//  input     in_valid / in_stall    code_bits, code_length
//  output    out_valid / out_stall  tone, is_preamble, last
//  config    cfg_we                 cfg_index, cfg_data
//
// a request is accepted, then each preamble tone is sent, then each code bit is shifted
// through the encoder, with an interleaver read and a data tone after every second code bit
// after reset the interleaver rams are swept to zero over all 4*INTERLEAVE_DEPTH rows,
// with in_stall high
// a stalled output holds the preamble and data states in place; in_stall stays high
// until the request is done
module thor_ifk_symbol_encoder_top #(
    parameter int INTERLEAVE_DEPTH = tise_pkg::INTERLEAVE_DEPTH_DEF,
    parameter int TONE_COUNT       = tise_pkg::TONE_COUNT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [tise_pkg::CODE_W-1:0]        code_bits,
    input  logic [tise_pkg::LEN_W-1:0]         code_length,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [tise_pkg::TONE_W-1:0]        tone,
    output logic                               is_preamble,
    output logic                               last,
    input  logic                               cfg_we,
    input  logic [tise_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tise_pkg::CFG_W-1:0]         cfg_data
);

    localparam int ROWS       = 4 * INTERLEAVE_DEPTH;
    localparam int RW         = $clog2(ROWS);
    localparam int TONE_STEPS = (TONE_COUNT + 16) / TONE_COUNT;
    localparam logic [RW:0]   ROWS_W   = (RW+1)'(ROWS);
    localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
    localparam logic [5:0]    TC6      = 6'(TONE_COUNT);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PRE  = 2'd1;
    localparam logic [1:0] ST_BIT  = 2'd2;
    localparam logic [1:0] ST_DATA = 2'd3;

    logic [1:0]                       state_reg, state_next;
    logic                             clearing_reg;
    logic [RW-1:0]                    clr_reg;
    logic [tise_pkg::CFG_W-1:0]       poly_a_reg, poly_b_reg;
    logic [tise_pkg::CODE_W-1:0]      bits_reg, bits_next;
    logic [tise_pkg::LEN_W-1:0]       bits_left_reg, bits_left_next;
    logic [tise_pkg::PRE_CNT_W-1:0]   pre_cnt_reg, pre_cnt_next;
    logic [tise_pkg::DATA_CNT_W-1:0]  data_left_reg, data_left_next;
    logic [tise_pkg::TONE_W-1:0]      cur_tone_reg, cur_tone_next;
    logic [tise_pkg::CFG_W-1:0]       pre_left_reg, pre_left_next;
    logic [tise_pkg::ENC_W-1:0]       enc_reg, enc_next;
    logic [1:0]                       held_pair_reg, held_pair_next;
    logic                             pending_reg, pending_next;
    logic [RW-1:0]                    row_reg, row_next;
    logic                             out_valid_reg, out_valid_next;
    logic [tise_pkg::TONE_W-1:0]      tone_reg, tone_next;
    logic                             is_pre_reg, is_pre_next;
    logic                             last_reg, last_next;

    logic                             accept;
    logic                             out_free;
    logic [tise_pkg::LEN_W-1:0]       len_sat;
    logic [tise_pkg::CODE_W-1:0]      aligned;
    logic [tise_pkg::PRE_CNT_W-1:0]   pre_take;
    logic [tise_pkg::LEN_W:0]         pair_sum;
    logic [tise_pkg::ENC_W-1:0]       enc_shifted;
    logic [1:0]                       coded;
    logic [3:0]                       group;
    logic                             group_go;
    logic [2:0]                       rd_bits;
    logic [3:0]                       nib;
    logic [tise_pkg::TONE_W-1:0]      pre_tone_step;
    logic [tise_pkg::TONE_W-1:0]      data_tone_step;

    assign accept   = in_valid && !in_stall;
    assign in_stall = clearing_reg || (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign tone        = tone_reg;
    assign is_preamble = is_pre_reg;
    assign last        = last_reg;

    // request setup: saturate length, left-align the code word, split the preamble
    assign len_sat  = (code_length > tise_pkg::MAX_BITS) ? tise_pkg::MAX_BITS : code_length;
    assign aligned  = code_bits << (tise_pkg::MAX_BITS - len_sat);
    assign pre_take = (pre_left_reg > 8'(tise_pkg::PREAMBLE_PER_ITEM))
                      ? tise_pkg::PREAMBLE_PER_ITEM : pre_left_reg[tise_pkg::PRE_CNT_W-1:0];
    assign pair_sum = {1'b0, len_sat} + {{tise_pkg::LEN_W{1'b0}}, pending_reg};

    // convolutional coder on the next shift value
    assign enc_shifted = {enc_reg[tise_pkg::ENC_W-2:0], bits_reg[tise_pkg::CODE_W-1]};
    assign coded       = {^(enc_shifted & poly_a_reg), ^(enc_shifted & poly_b_reg)};
    assign group       = {held_pair_reg, coded};
    assign group_go    = (state_reg == ST_BIT) && pending_reg;

    // column 0 of the read row is the bit just written, the rest come from the rams
    assign nib = {held_pair_reg[1], rd_bits[0], rd_bits[1], rd_bits[2]};

    // preamble tone step
    always_comb
    begin
        logic [5:0] sum;
        sum = {1'b0, cur_tone_reg} + 6'd2;
        if (sum >= TC6)
        begin
            sum = sum - TC6;
        end
        pre_tone_step = sum[tise_pkg::TONE_W-1:0];
    end

    // data tone step: tone + 2 + nibble, reduced by repeated subtract
    always_comb
    begin
        logic [5:0] sum;
        sum = {1'b0, cur_tone_reg} + 6'd2 + {2'b00, nib};
        for (int i = 0; i < TONE_STEPS; i++)
        begin
            if (sum >= TC6)
            begin
                sum = sum - TC6;
            end
        end
        data_tone_step = sum[tise_pkg::TONE_W-1:0];
    end

    // interleaver rams, one per column 1..3, rows of the diagonal write
    genvar gj;
    generate
        for (gj = 0; gj < 3; gj++)
        begin : g_bank
            localparam logic [RW:0] OFS = (RW+1)'((gj + 1) * INTERLEAVE_DEPTH);
            logic          bank_ram [ROWS];
            logic [RW:0]   sum;
            logic [RW-1:0] waddr;
            logic          rd_bit_reg;

            assign sum   = {1'b0, row_reg} + OFS;
            assign waddr = clearing_reg ? clr_reg
                         : ((sum >= ROWS_W) ? RW'(sum - ROWS_W) : sum[RW-1:0]);

            always_ff @(posedge clk)
            begin
                if (clearing_reg || group_go)
                begin
                    bank_ram[waddr] <= clearing_reg ? 1'b0 : group[2 - gj];
                end
                if (group_go)
                begin
                    rd_bit_reg <= bank_ram[row_reg];
                end
            end

            assign rd_bits[gj] = rd_bit_reg;
        end
    endgenerate

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        bits_next      = bits_reg;
        bits_left_next = bits_left_reg;
        pre_cnt_next   = pre_cnt_reg;
        data_left_next = data_left_reg;
        cur_tone_next  = cur_tone_reg;
        pre_left_next  = pre_left_reg;
        enc_next       = enc_reg;
        held_pair_next = held_pair_reg;
        pending_next   = pending_reg;
        row_next       = row_reg;
        out_valid_next = out_valid_reg && out_stall;
        tone_next      = tone_reg;
        is_pre_next    = is_pre_reg;
        last_next      = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    bits_next      = aligned;
                    bits_left_next = len_sat;
                    pre_cnt_next   = pre_take;
                    pre_left_next  = pre_left_reg - 8'(pre_take);
                    data_left_next = pair_sum[tise_pkg::DATA_CNT_W:1];
                    if (pre_take != '0)
                    begin
                        state_next = ST_PRE;
                    end
                    else if (len_sat != '0)
                    begin
                        state_next = ST_BIT;
                    end
                end
            end
            ST_PRE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    tone_next      = cur_tone_reg;
                    is_pre_next    = 1'b1;
                    last_next      = (pre_cnt_reg == 5'd1) && (data_left_reg == '0);
                    cur_tone_next  = pre_tone_step;
                    pre_cnt_next   = pre_cnt_reg - 5'd1;
                    if (pre_cnt_reg == 5'd1)
                    begin
                        state_next = (bits_left_reg != '0) ? ST_BIT : ST_IDLE;
                    end
                end
            end
            ST_BIT:
            begin
                bits_next      = {bits_reg[tise_pkg::CODE_W-2:0], 1'b0};
                bits_left_next = bits_left_reg - 4'd1;
                enc_next       = enc_shifted;
                if (pending_reg)
                begin
                    pending_next = 1'b0;
                    state_next   = ST_DATA;
                end
                else
                begin
                    held_pair_next = coded;
                    pending_next   = 1'b1;
                    if (bits_left_reg == 4'd1)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DATA:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    tone_next      = cur_tone_reg;
                    is_pre_next    = 1'b0;
                    last_next      = (data_left_reg == 3'd1);
                    cur_tone_next  = data_tone_step;
                    data_left_next = data_left_reg - 3'd1;
                    row_next       = (row_reg == ROW_LAST) ? '0 : row_reg + 1'b1;
                    state_next     = (bits_left_reg != '0) ? ST_BIT : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            clearing_reg  <= 1'b1;
            clr_reg       <= '0;
            bits_left_reg <= '0;
            pre_cnt_reg   <= '0;
            data_left_reg <= '0;
            cur_tone_reg  <= '0;
            pre_left_reg  <= tise_pkg::PREAMBLE_LEN_RESET;
            enc_reg       <= '0;
            held_pair_reg <= '0;
            pending_reg   <= 1'b0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bits_left_reg <= bits_left_next;
            pre_cnt_reg   <= pre_cnt_next;
            data_left_reg <= data_left_next;
            cur_tone_reg  <= cur_tone_next;
            pre_left_reg  <= pre_left_next;
            enc_reg       <= enc_next;
            held_pair_reg <= held_pair_next;
            pending_reg   <= pending_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
            // ram clearing sweep
            if (clearing_reg)
            begin
                clr_reg <= (clr_reg == ROW_LAST) ? '0 : clr_reg + 1'b1;
                if (clr_reg == ROW_LAST)
                begin
                    clearing_reg <= 1'b0;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        bits_reg   <= bits_next;
        tone_reg   <= tone_next;
        is_pre_reg <= is_pre_next;
        last_reg   <= last_next;
    end

    // configuration registers; preamble length only matters at reset, which loads
    // the reset constant into the preamble counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_a_reg <= tise_pkg::POLY_A_RESET;
            poly_b_reg <= tise_pkg::POLY_B_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tise_pkg::REG_POLY_A:       poly_a_reg <= cfg_data;
                tise_pkg::REG_POLY_B:       poly_b_reg <= cfg_data;
                tise_pkg::REG_PREAMBLE_LEN: poly_a_reg <= poly_a_reg;
                default:                    poly_b_reg <= poly_b_reg;
            endcase
        end
    end

endmodule

// ===== rtl/tise_checker.sv =====
// port-level checks for the thor ifk symbol encoder, bound to the top level
module tise_checker #(
    parameter int TONE_COUNT = tise_pkg::TONE_COUNT_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic [tise_pkg::CODE_W-1:0]   code_bits,
    input logic [tise_pkg::LEN_W-1:0]    code_length,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [tise_pkg::TONE_W-1:0]   tone,
    input logic                          is_preamble,
    input logic                          last
);

    localparam logic [5:0] TC6 = 6'(TONE_COUNT);

    logic [5:0] tone_plus2;
    logic [5:0] pre_expect;

    // expected next preamble tone
    assign tone_plus2 = {1'b0, tone} + 6'd2;
    assign pre_expect = (tone_plus2 >= TC6) ? tone_plus2 - TC6 : tone_plus2;

    // a stalled output holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(tone) && $stable(is_preamble)
            && $stable(last))
        else $error("stalled output changed");

    // tones stay in range
    a_tone_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, tone} < TC6))
        else $error("tone out of range");

    // a request with code bits keeps the input side busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (code_length != '0) |=> in_stall)
        else $error("input not stalled after accepting code bits");

    // a stalled input request holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(code_bits) && $stable(code_length))
        else $error("stalled input request changed");

    // preamble tones step by two
    a_pre_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && is_preamble && !last
        |=> !out_valid || !is_preamble || ({1'b0, tone} == $past(pre_expect)))
        else $error("preamble tone did not step by two");

endmodule

bind thor_ifk_symbol_encoder_top tise_checker #(.TONE_COUNT(TONE_COUNT)) u_tise_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .code_bits   (code_bits),
    .code_length (code_length),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .tone        (tone),
    .is_preamble (is_preamble),
    .last        (last)
);
